FILE: rtl/core/pf_pkg.sv
package pf_pkg;

  // default operand width and cap on factors per run
  localparam int VALUE_BITS_DEF = 31;
  localparam int MAX_RESULTS    = 30;
  localparam int CNT_W          = $clog2(MAX_RESULTS + 1);

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_WAIT,
    ST_EVAL,
    ST_PUSH,
    ST_FIN,
    ST_FLUSH
  } state_t;

  // which divisor is being stripped
  typedef enum logic [1:0] {
    PH_TWO,
    PH_THREE,
    PH_LO,
    PH_HI
  } phase_t;

endpackage

FILE: rtl/core/prime_factorizer.sv
// work: a prime near 2^31 takes about 7700 candidate pairs, some 15450 divisions, all
//   run on the shared divider
// throughput: one item at a time; s_tready is high only while the sequencer is idle
// factors leave one beat each, ascending, tlast on the final one; 0 and 1 give none
// reset: synchronous active-high rst returns the sequencer to idle and drops any
//   beat not yet taken
module prime_factorizer #(
  parameter int VALUE_BITS = pf_pkg::VALUE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] s_tdata,  // value
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [((VALUE_BITS + 7) / 8) * 8-1:0] m_tdata,  // factor
  output logic                                 m_tlast
);

  localparam int W  = VALUE_BITS;
  localparam int TW = ((VALUE_BITS + 7) / 8) * 8;

  pf_pkg::state_t state, state_next;
  pf_pkg::phase_t phase;

  logic                   chk;         // bound test pending for this candidate
  logic [W-1:0]           rem;         // remaining cofactor
  logic [W-1:0]           d;           // current trial divisor
  logic [W-1:0]           fac;         // factor found, waiting to enter pend
  logic [W-1:0]           pend;        // held back until we know if it is last
  logic                   pend_valid;
  logic [pf_pkg::CNT_W-1:0] cnt;       // factors taken into this run
  logic [W-1:0]           out_data;

  logic                   div_start;
  logic                   div_done;
  logic [W-1:0]           div_quot;
  logic [W-1:0]           div_rmd;

  logic                   out_free;
  logic                   push_go;
  logic                   flush_go;
  logic                   send_go;
  logic                   is_factor;
  logic                   stop_bound;
  logic [W-1:0]           in_value;

  assign in_value = s_tdata[W-1:0];

  // shared divider: every strip step and bound test uses one rem / d
  pf_div #(
    .W(W)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rem),
    .divisor  (d),
    .done     (div_done),
    .quot     (div_quot),
    .rmd      (div_rmd)
  );

  // control outputs of the sequencer
  always_comb begin
    s_tready   = (state == pf_pkg::ST_IDLE);
    div_start  = (state == pf_pkg::ST_START);
    out_free   = !m_tvalid || m_tready;
    push_go    = (state == pf_pkg::ST_PUSH) && (!pend_valid || out_free);
    flush_go   = (state == pf_pkg::ST_FLUSH) && (!pend_valid || out_free);
    // held factor moves into the output beat
    send_go    = (push_go || flush_go) && pend_valid;
    // rem >= d and d divides rem
    is_factor  = (div_quot != '0) && (div_rmd == '0);
    // loop ends once d*d > rem, tested as d > rem / d
    stop_bound = chk && (d > div_quot);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pf_pkg::ST_IDLE: begin
        if (s_tvalid && (in_value > W'(1))) state_next = pf_pkg::ST_START;
      end
      pf_pkg::ST_START: state_next = pf_pkg::ST_WAIT;
      pf_pkg::ST_WAIT: begin
        if (div_done) state_next = pf_pkg::ST_EVAL;
      end
      pf_pkg::ST_EVAL: begin
        if (stop_bound)     state_next = pf_pkg::ST_FIN;
        else if (is_factor) state_next = pf_pkg::ST_PUSH;
        else                state_next = pf_pkg::ST_START;
      end
      pf_pkg::ST_PUSH: begin
        if (push_go) begin
          if (cnt == pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS - 1)) state_next = pf_pkg::ST_FLUSH;
          else if (rem == W'(1))                              state_next = pf_pkg::ST_FIN;
          else                                                state_next = pf_pkg::ST_START;
        end
      end
      pf_pkg::ST_FIN: begin
        if (rem > W'(1)) state_next = pf_pkg::ST_PUSH;
        else             state_next = pf_pkg::ST_FLUSH;
      end
      pf_pkg::ST_FLUSH: begin
        if (flush_go) state_next = pf_pkg::ST_IDLE;
      end
      default: state_next = pf_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= pf_pkg::ST_IDLE;
      m_tvalid   <= 1'b0;
      pend_valid <= 1'b0;
      cnt        <= '0;
      chk        <= 1'b0;
      phase      <= pf_pkg::PH_TWO;
    end else begin
      state <= state_next;
      if (send_go)                   m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;

      case (state)
        pf_pkg::ST_IDLE: begin
          if (s_tvalid) begin
            rem        <= in_value;
            d          <= W'(2);
            phase      <= pf_pkg::PH_TWO;
            chk        <= 1'b0;
            cnt        <= '0;
            pend_valid <= 1'b0;
          end
        end
        pf_pkg::ST_EVAL: begin
          if (!stop_bound) begin
            if (is_factor) begin
              fac <= d;
              rem <= div_quot;
              chk <= 1'b0;
            end else begin
              // step through 2, 3, then the 6k-1 / 6k+1 wheel
              case (phase)
                pf_pkg::PH_TWO: begin
                  d     <= W'(3);
                  phase <= pf_pkg::PH_THREE;
                  chk   <= 1'b0;
                end
                pf_pkg::PH_THREE: begin
                  d     <= W'(5);
                  phase <= pf_pkg::PH_LO;
                  chk   <= 1'b1;
                end
                pf_pkg::PH_LO: begin
                  d     <= d + W'(2);
                  phase <= pf_pkg::PH_HI;
                  chk   <= 1'b0;
                end
                pf_pkg::PH_HI: begin
                  d     <= d + W'(4);
                  phase <= pf_pkg::PH_LO;
                  chk   <= 1'b1;
                end
                default: begin
                  phase <= pf_pkg::PH_TWO;
                  chk   <= 1'b0;
                end
              endcase
            end
          end
        end
        pf_pkg::ST_FIN: begin
          // leftover cofactor above one is the largest prime
          if (rem > W'(1)) begin
            fac <= rem;
            rem <= W'(1);
          end
        end
        pf_pkg::ST_PUSH: begin
          if (push_go) begin
            if (pend_valid) begin
              out_data <= pend;
              m_tlast  <= 1'b0;
            end
            pend       <= fac;
            pend_valid <= 1'b1;
            cnt        <= cnt + 1'b1;
          end
        end
        pf_pkg::ST_FLUSH: begin
          if (flush_go && pend_valid) begin
            out_data   <= pend;
            m_tlast    <= 1'b1;
            pend_valid <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  assign m_tdata = TW'(out_data);

`ifndef ASSERT_OFF
  a_idle_no_pend: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("held factor left over when idle");

  a_cnt_cap: assert property (@(posedge clk) disable iff (rst)
    cnt <= pf_pkg::CNT_W'(pf_pkg::MAX_RESULTS))
    else $error("factor count beyond cap");

  a_wheel_odd: assert property (@(posedge clk) disable iff (rst)
    (state != pf_pkg::ST_IDLE && (phase == pf_pkg::PH_LO || phase == pf_pkg::PH_HI))
      |-> d[0])
    else $error("wheel candidate is even");

  a_push_needs_slot: assert property (@(posedge clk) disable iff (rst)
    (push_go && pend_valid) |-> out_free)
    else $error("factor pushed over an untaken beat");
`endif

endmodule

FILE: rtl/core/pf_div.sv
module pf_div #(
  parameter int W = pf_pkg::VALUE_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quot,
  output logic [W-1:0] rmd
);

  localparam int SW = $clog2(W + 1);

  logic          busy;
  logic [SW-1:0] step;
  logic [W-1:0]  q;
  logic [W-1:0]  r;
  logic [W-1:0]  dvs;
  logic [W:0]    rshift;
  logic [W:0]    diff;
  logic          ge;

  // one restoring step per cycle
  always_comb begin
    rshift = {r, q[W-1]};
    diff   = rshift - {1'b0, dvs};
    ge     = !diff[W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        r    <= '0;
        dvs  <= divisor;
        step <= SW'(W);
        busy <= 1'b1;
      end else if (busy) begin
        r    <= ge ? diff[W-1:0] : rshift[W-1:0];
        q    <= {q[W-2:0], ge};
        step <= step - 1'b1;
        if (step == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quot = q;
  assign rmd  = r;

`ifndef ASSERT_OFF
  a_rmd_below_div: assert property (@(posedge clk) disable iff (rst)
    done |-> (rmd < dvs))
    else $error("remainder not below divisor");

  a_busy_count: assert property (@(posedge clk) disable iff (rst)
    busy |-> (step != '0))
    else $error("divider busy with zero step count");
`endif

endmodule

FILE: sim/prime_factorizer_test.sv
`timescale 1ns / 1ps

module prime_factorizer_test;

  // operand width and bus width as the block is built here
  localparam int VB = pf_pkg::VALUE_BITS_DEF;
  localparam int DW = ((VB + 7) / 8) * 8;
  // cycles charged per trial division, with some margin over the divider latency
  localparam int DIV_CYCLES = 40;

  typedef logic [VB-1:0] value_t;

  typedef struct packed {
    value_t factor;
    logic   last;
  } factor_beat_t;

  // holds the factors still owed by the block, oldest first
  class factor_scoreboard;
    factor_beat_t     owed_q[$];
    int unsigned      errors;
    int unsigned      values_seen;
    int unsigned      empty_runs;
    int unsigned      factors_checked;
    longint unsigned  cycle_budget;

    // divides out every copy of d, owing one factor per copy up to MAX_RESULTS
    function void strip_divisor(inout longint unsigned rem, input longint unsigned d,
                                inout int n);
      factor_beat_t b;
      while (rem >= d && (rem % d) == 0) begin
        if (n < pf_pkg::MAX_RESULTS) begin
          b.factor = d[VB-1:0];
          b.last   = 1'b0;
          owed_q.push_back(b);
          n++;
        end
        rem = rem / d;
      end
    endfunction

    // factors one accepted value by 6k+-1 trial division
    function void note_value(value_t v);
      longint unsigned rem;
      longint unsigned c;
      longint unsigned pairs;
      int n;
      factor_beat_t b;
      rem   = v;
      pairs = 0;
      n     = 0;
      values_seen++;
      if (rem <= 1) begin
        empty_runs++;
        cycle_budget += 100;
        return;
      end
      strip_divisor(rem, 2, n);
      strip_divisor(rem, 3, n);
      for (c = 5; c <= rem / c; c += 6) begin
        strip_divisor(rem, c, n);
        strip_divisor(rem, c + 2, n);
        pairs++;
      end
      if (rem > 1 && n < pf_pkg::MAX_RESULTS) begin
        b.factor = rem[VB-1:0];
        b.last   = 1'b0;
        owed_q.push_back(b);
        n++;
      end
      // the final factor of this run carries tlast
      b = owed_q.pop_back();
      b.last = 1'b1;
      owed_q.push_back(b);
      cycle_budget += (2 * pairs + 3 * n + 6) * DIV_CYCLES + 60 * n + 100;
    endfunction

    function void check_factor(value_t f, logic l);
      factor_beat_t want;
      if (owed_q.size() == 0) begin
        $error("factor beat %0d with nothing expected", f);
        errors++;
        return;
      end
      want = owed_q.pop_front();
      factors_checked++;
      if (f != want.factor) begin
        $error("factor: expected %0d, got %0d", want.factor, f);
        errors++;
      end
      if (l != want.last) begin
        $error("last: expected %0d, got %0d", want.last, l);
        errors++;
      end
    endfunction

    function void finish_check();
      if (owed_q.size() != 0) begin
        $error("%0d factor beats never arrived", owed_q.size());
        errors++;
      end
    endfunction
  endclass

  logic          clk      = 1'b0;
  logic          rst      = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [DW-1:0] s_tdata  = '0;  // value
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [DW-1:0] m_tdata;        // factor
  logic          m_tlast;

  factor_scoreboard sb = new;

  // percentages of idle sender cycles and stalled receiver cycles
  int unsigned     idle_pct  = 0;
  int unsigned     stall_pct = 0;
  longint unsigned cycles    = 0;

  // edge-case values: empty runs, small primes and powers, squares that sit
  // right on the candidate bound, the longest run, and the largest prime
  longint unsigned directed_q[$] = {
    0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 25, 35, 49, 121, 143, 30030, 65521,
    1018081, 1162261467, 1073741824, 2147483646, 2147483647
  };

  prime_factorizer #(
    .VALUE_BITS(VB)
  ) u_dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // output monitor and watchdog; the limit grows with the work handed to the block
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      sb.check_factor(m_tdata[VB-1:0], m_tlast);
    end
    if (cycles > 200000 + 4 * sb.cycle_budget) begin
      $display("timeout after %0d cycles", cycles);
      $display("prime_factorizer_test failed");
      $finish;
    end
  end

  // one input beat, with random idle cycles ahead of it
  task automatic send_value(input value_t v);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= DW'(v);
    do @(posedge clk); while (!s_tready);
    sb.note_value(v);
  endtask

  // random values kept cheap to factor: short values, products of small
  // numbers that reach the top bits, and shifted mid-size values whose
  // cofactor may be a prime of up to 20 bits
  function automatic value_t random_value();
    longint unsigned v;
    longint unsigned f;
    int w;
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        w = $urandom_range(1, 16);
        v = longint'($urandom) & ((64'd1 << w) - 1);
      end
      4, 5, 6, 7: begin
        v = 1;
        repeat ($urandom_range(1, 30)) begin
          f = $urandom_range(2, 250);
          if (v * f < (64'd1 << VB)) v = v * f;
        end
      end
      default: begin
        v = longint'($urandom_range(1, (1 << 20) - 1)) << $urandom_range(0, 10);
      end
    endcase
    return v[VB-1:0];
  endfunction

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part with both sides free running
    foreach (directed_q[i]) send_value(directed_q[i][VB-1:0]);

    // random part: free running, idle sender, stalling receiver, then both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 69; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 69; end
        default: begin idle_pct = 23; stall_pct = 23; end
      endcase
      repeat (20) send_value(random_value());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;

    // drain, then watch a while longer for stray beats
    while (sb.owed_q.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    sb.finish_check();

    $display("factored %0d values (%0d of them 0 or 1), %0d factor beats compared",
             sb.values_seen, sb.empty_runs, sb.factors_checked);
    $display("covered under free flow, idle sender, stalled receiver and mixed gaps");
    if (sb.errors == 0) begin
      $display("prime_factorizer_test passed");
    end else begin
      $display("prime_factorizer_test failed");
    end
    $finish;
  end

endmodule
